// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the governor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define CTFG_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Expression must never be true outside reset.
`define CTFG_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

// ===== hdl/ctfg_pkg.sv =====
// Shared widths, codes, reset values and types of the frequency governor.
package ctfg_pkg;

    // Field widths.
    localparam int CAP_W  = 11;
    localparam int FREQ_W = 24;
    localparam int PER_W  = 32;
    localparam int PROD_W = CAP_W + FREQ_W;
    localparam int MASK_W = 8;
    localparam int CMD_W  = 2;
    localparam int CPU_W  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Default number of CPUs in the cluster.
    localparam int NUM_CPUS_DEF = 8;

    // Item commands.
    localparam logic [CMD_W-1:0] CMD_SET   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RESET = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MASK     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_MAX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAP_ORIG = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [MASK_W-1:0] RST_MASK     = 8'hFF;
    localparam logic [FREQ_W-1:0] RST_FREQ_MAX = 24'd2000000;
    localparam logic [CAP_W-1:0]  RST_CAP_ORIG = 11'd1024;
    localparam logic [PER_W-1:0]  RST_PERIOD   = 32'd20000;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic              enable;
        logic [MASK_W-1:0] cluster_mask;
        logic [FREQ_W-1:0] freq_max;
        logic [CAP_W-1:0]  capacity_orig;
        logic [PER_W-1:0]  throttle_period;
    } t_cfg;

endpackage

// ===== hdl/ctfg_regs.sv =====
// Configuration register file of the frequency governor.
module ctfg_regs
    import ctfg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Decode the write index; indexes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable          <= 1'b0;
            r_cfg.cluster_mask    <= RST_MASK;
            r_cfg.freq_max        <= RST_FREQ_MAX;
            r_cfg.capacity_orig   <= RST_CAP_ORIG;
            r_cfg.throttle_period <= RST_PERIOD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ENABLE:   r_cfg.enable          <= i_cfg_data[0];
                REG_MASK:     r_cfg.cluster_mask    <= i_cfg_data[MASK_W-1:0];
                REG_FREQ_MAX: r_cfg.freq_max        <= i_cfg_data[FREQ_W-1:0];
                REG_CAP_ORIG: r_cfg.capacity_orig   <= i_cfg_data[CAP_W-1:0];
                REG_PERIOD:   r_cfg.throttle_period <= i_cfg_data[PER_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/ctfg_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
module ctfg_div
    import ctfg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PROD_W-1:0] i_dividend,
    input  logic [CAP_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [PROD_W-1:0] o_quotient
);

    `include "assert_macros.svh"

    localparam int CNT_W = $clog2(PROD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PROD_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [CAP_W:0]    r_rem;
    logic [PROD_W-1:0] r_quot;
    logic [CAP_W-1:0]  r_div;

    logic [CAP_W:0] w_rem_sh;
    logic           w_ge;

    // Shift in the next dividend bit and try a subtraction.
    assign w_rem_sh = {r_rem[CAP_W-1:0], r_quot[PROD_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_div});

    // Control: busy for one cycle per quotient bit, then a done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend register turns into the quotient bit by bit.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[PROD_W-2:0], w_ge};
            r_rem  <= w_ge ? (w_rem_sh - {1'b0, r_div}) : w_rem_sh;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quot;

    `CTFG_ASSERT_NEVER(a_no_restart, i_clk, i_rst_n, r_busy && i_start, "divider restarted while busy")

endmodule

// ===== hdl/capacity_to_frequency_governor.sv =====
// A set item that passes the throttle walks the capacity table, then goes through the
// multiply and the 35-step serial divider; an item stopped in the walk, like any other item,
// goes straight to the result. One item is in work at a time; the input is ready again
// once its result is registered. Reset (synchronous, active low) restores the configuration
// and control registers, zeroes the capacity table and the throttle countdown, and needs no
// clearing pass.
module capacity_to_frequency_governor
    import ctfg_pkg::*;
#(
    parameter int NUM_CPUS = NUM_CPUS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Input channel.
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic [CPU_W-1:0]      i_cpu_index,
    input  logic [CAP_W-1:0]      i_capacity,
    input  logic [FREQ_W-1:0]     i_current_freq,
    // Result channel.
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_request_valid,
    output logic [FREQ_W-1:0]     o_new_freq
);

    `include "assert_macros.svh"

    localparam int IDX_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int WALK_N = (NUM_CPUS < MASK_W) ? NUM_CPUS : MASK_W;
    localparam logic [IDX_W-1:0] WALK_LAST = IDX_W'(WALK_N - 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_WALK = 6'b000010,
        S_MUL  = 6'b000100,
        S_DIVS = 6'b001000,
        S_DIVW = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_cfg w_cfg;

    t_state r_state, n_state;
    logic [CAP_W-1:0]  r_table [NUM_CPUS];
    logic [PER_W-1:0]  r_throttle;
    logic [IDX_W-1:0]  r_walk;
    logic              r_fail;
    logic [CAP_W-1:0]  r_cap;
    logic [FREQ_W-1:0] r_cur;
    logic [PROD_W-1:0] r_prod;
    logic              r_issue;
    logic [FREQ_W-1:0] r_freq;
    logic              r_out_valid;
    logic              r_out_req;
    logic [FREQ_W-1:0] r_out_freq;

    logic              w_accept;
    logic              w_cpu_ok;
    logic [7:0]        w_cpu8;
    logic [IDX_W-1:0]  w_cpu_idx;
    logic              w_set_ok;
    logic [7:0]        w_walk8;
    logic              w_over;
    logic [CAP_W-1:0]  w_divisor;
    logic              w_div_done;
    logic [PROD_W-1:0] w_quot;
    logic [FREQ_W-1:0] w_sat;
    logic              w_issue;
    logic              w_out_free;

    ctfg_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // A zero divisor is taken as one.
    assign w_divisor = (w_cfg.capacity_orig == '0) ? CAP_W'(1) : w_cfg.capacity_orig;

    ctfg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DIVS),
        .i_dividend (r_prod),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // Input decode.
    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_cpu_ok   = (32'(i_cpu_index) < NUM_CPUS);
    assign w_cpu8     = 8'(i_cpu_index);
    assign w_cpu_idx  = w_cpu8[IDX_W-1:0];
    assign w_set_ok   = (i_cmd == CMD_SET) && w_cfg.enable && w_cpu_ok;

    // One table entry per walk step; an entry in the cluster mask that is above the new request blocks it.
    assign w_walk8 = 8'(r_walk);
    assign w_over  = w_cfg.cluster_mask[w_walk8[2:0]] && (r_table[r_walk] > r_cap);

    // Saturate the quotient to the frequency field.
    assign w_sat   = (w_quot[PROD_W-1:FREQ_W] != '0) ? '1 : w_quot[FREQ_W-1:0];
    assign w_issue = (w_sat != r_cur);

    assign w_out_free = !r_out_valid || i_out_ready;

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (w_set_ok && r_throttle == '0) ? S_WALK : S_DONE;
                end
            end
            S_WALK: begin
                if (r_walk == WALK_LAST) begin
                    n_state = (r_fail || w_over) ? S_DONE : S_MUL;
                end
            end
            S_MUL:  n_state = S_DIVS;
            S_DIVS: n_state = S_DIVW;
            S_DIVW: begin
                if (w_div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Capacity table: set and reset items write at transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CPUS; i++) begin
                r_table[i] <= '0;
            end
        end else if (w_accept && w_set_ok) begin
            r_table[w_cpu_idx] <= i_capacity;
        end else if (w_accept && i_cmd == CMD_RESET && w_cpu_ok) begin
            r_table[w_cpu_idx] <= '0;
        end
    end

    // Control state: sequencer, throttle countdown and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_throttle  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept && i_cmd == CMD_TICK && r_throttle != '0) begin
                r_throttle <= r_throttle - 1'b1;
            end else if (r_state == S_DIVW && w_div_done && w_issue) begin
                r_throttle <= w_cfg.throttle_period;
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_walk  <= '0;
                r_fail  <= 1'b0;
                r_cap   <= i_capacity;
                r_cur   <= i_current_freq;
                r_issue <= 1'b0;
                r_freq  <= '0;
            end
            S_WALK: begin
                r_walk <= r_walk + 1'b1;
                r_fail <= r_fail || w_over;
            end
            S_MUL: begin
                r_prod <= PROD_W'(r_cap) * PROD_W'(w_cfg.freq_max);
            end
            S_DIVW: begin
                if (w_div_done) begin
                    r_issue <= w_issue;
                    r_freq  <= w_issue ? w_sat : '0;
                end
            end
            default: ;
        endcase
    end

    // Result register: loaded once the previous result has been taken.
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out_req  <= r_issue;
            r_out_freq <= r_freq;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_request_valid = r_out_req;
    assign o_new_freq      = r_out_freq;

    `CTFG_ASSERT(a_busy_after_xfer, i_clk, i_rst_n, (w_accept |=> !o_in_ready), "ready right after an input transfer")
    `CTFG_ASSERT(a_walk_unthrottled, i_clk, i_rst_n, ((r_state == S_WALK) |-> (r_throttle == '0)), "walk while throttled")
    `CTFG_ASSERT(a_no_req_zero_freq, i_clk, i_rst_n, ((o_out_valid && !o_request_valid) |-> (o_new_freq == '0)), "frequency without request")

endmodule
